[hw/rtl/pisq_pkg.sv]
package pisq_pkg;
   localparam int StepBits = 31;
   localparam int DivBits  = 32;
   localparam int Slices   = 2;
   localparam int CsrBits  = 3;
   localparam logic [StepBits-1:0] NoneStep = {StepBits{1'b1}};

   localparam logic [CsrBits-1:0] CsrFirstStart   = 3'd0;
   localparam logic [CsrBits-1:0] CsrFirstStop    = 3'd1;
   localparam logic [CsrBits-1:0] CsrFirstPeriod  = 3'd2;
   localparam logic [CsrBits-1:0] CsrSecondStart  = 3'd3;
   localparam logic [CsrBits-1:0] CsrSecondStop   = 3'd4;
   localparam logic [CsrBits-1:0] CsrSecondPeriod = 3'd5;

   // per-slice remainder lanes: d = step - start, e = |lim - start|
   typedef struct packed {
      logic                dge;
      logic                eneg;
      logic [DivBits-1:0]  dq;
      logic [DivBits-1:0]  eq;
      logic [StepBits-1:0] rd;
      logic [StepBits-1:0] re;
   } lane_type;

   typedef struct packed {
      logic                vld;
      logic [StepBits-1:0] step;
      lane_type [Slices-1:0] lane;
   } item_type;

   typedef struct packed {
      logic                member;
      logic [StepBits-1:0] nxt;
      logic [StepBits-1:0] prv;
   } slice_res_type;
endpackage

[hw/rtl/pisq_cell.sv]
module pisq_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic [pisq_pkg::Slices-1:0][pisq_pkg::StepBits-1:0] period,
   input  pisq_pkg::item_type                   item_i,
   output pisq_pkg::item_type                   item_o
);
   pisq_pkg::item_type item_ff, item_in;

   function automatic logic [pisq_pkg::StepBits-1:0] rem_step(
      input logic [pisq_pkg::StepBits-1:0] r,
      input logic                          b,
      input logic [pisq_pkg::StepBits-1:0] p);
      logic [pisq_pkg::StepBits:0] t;
      t = {r, b};
      if (t >= {1'b0, p}) t = t - {1'b0, p};
      return t[pisq_pkg::StepBits-1:0];
   endfunction

   always_comb begin
      item_in = item_i;
      for (int s = 0; s < pisq_pkg::Slices; s++) begin
         item_in.lane[s].rd = rem_step(item_i.lane[s].rd, item_i.lane[s].dq[pisq_pkg::DivBits-1],
                                       period[s]);
         item_in.lane[s].re = rem_step(item_i.lane[s].re, item_i.lane[s].eq[pisq_pkg::DivBits-1],
                                       period[s]);
         item_in.lane[s].dq = {item_i.lane[s].dq[pisq_pkg::DivBits-2:0], 1'b0};
         item_in.lane[s].eq = {item_i.lane[s].eq[pisq_pkg::DivBits-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.vld <= 1'b0;
      end else if (adv) begin
         item_ff.vld <= item_in.vld;
      end
      if (adv) begin
         item_ff.step <= item_in.step;
         item_ff.lane <= item_in.lane;
      end
   end

   assign item_o = item_ff;
endmodule

[hw/rtl/pisq_post.sv]
module pisq_post (
   input  logic [pisq_pkg::StepBits-1:0] step,
   input  logic [pisq_pkg::StepBits-1:0] start,
   input  logic [pisq_pkg::StepBits-1:0] stop,
   input  logic [pisq_pkg::StepBits-1:0] period,
   input  pisq_pkg::lane_type            lane,
   output pisq_pkg::slice_res_type       res
);
   logic               en;
   logic signed [33:0] n34, st34, sp34, p34, nx, m, pv;

   always_comb begin
      en   = period != '0;
      n34  = $signed({3'b0, step});
      st34 = $signed({3'b0, start});
      sp34 = $signed({3'b0, stop});
      p34  = $signed({3'b0, period});
      nx   = n34 - $signed({3'b0, lane.rd}) + p34;
      if (!lane.dge) nx = st34;
      if (nx > sp34 || !en) nx = $signed({3'b0, pisq_pkg::NoneStep});
      // truncating quotient times period is magnitude minus remainder
      m  = $signed({2'b0, lane.eq}) - $signed({3'b0, lane.re});
      pv = lane.eneg ? st34 - m : st34 + m;
      if (!en || !lane.dge || pv < 0) pv = '0;
      res.member = en && lane.dge && (step <= stop) && (lane.rd == '0);
      res.nxt    = nx[pisq_pkg::StepBits-1:0];
      res.prv    = pv[pisq_pkg::StepBits-1:0];
   end
endmodule

[hw/rtl/periodic_interval_step_query_unit.sv]
// channel   ports                         direction
// req       req_valid/ready, req_step     in
// rsp       rsp_valid/ready, rsp_*        out
// csr       csr_valid/ready, index, data  in
// One request per cycle unless the response stalls; one setup stage, 32 remainder
// cells (one dividend bit each, both slices side by side), one slice stage,
// and the output register.
// Synchronous reset empties the pipe and loads the default slices.
// A stalled response freezes the whole pipe; csr is always ready.
module periodic_interval_step_query_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pisq_pkg::StepBits-1:0]  req_step,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_is_member,
   output logic [pisq_pkg::StepBits-1:0]  rsp_next_step,
   output logic [pisq_pkg::StepBits-1:0]  rsp_prior_step,
   output logic [pisq_pkg::StepBits-1:0]  rsp_local_gap,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pisq_pkg::CsrBits-1:0]   csr_index,
   input  logic [pisq_pkg::StepBits-1:0]  csr_data
);
   localparam int W = pisq_pkg::StepBits;
   localparam int S = pisq_pkg::Slices;
   localparam int D = pisq_pkg::DivBits;

   logic [S-1:0][W-1:0] start_ff, stop_ff, period_ff;
   logic adv;

   pisq_pkg::item_type chain [D+1];
   pisq_pkg::item_type prep_in;
   pisq_pkg::slice_res_type [S-1:0] sres;
   pisq_pkg::slice_res_type [S-1:0] sres_ff;
   logic [W-1:0] post_step_ff;
   logic post_vld_ff;

   logic          rsp_valid_ff, member_in, member_ff;
   logic [W-1:0]  next_in, next_ff, prior_in, prior_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         stop_ff   <= {S{pisq_pkg::NoneStep}};
         period_ff <= {{W{1'b0}}, W'(1)};
      end else if (csr_valid) begin
         case (csr_index)
            pisq_pkg::CsrFirstStart:   start_ff[0]  <= csr_data;
            pisq_pkg::CsrFirstStop:    stop_ff[0]   <= csr_data;
            pisq_pkg::CsrFirstPeriod:  period_ff[0] <= csr_data;
            pisq_pkg::CsrSecondStart:  start_ff[1]  <= csr_data;
            pisq_pkg::CsrSecondStop:   stop_ff[1]   <= csr_data;
            pisq_pkg::CsrSecondPeriod: period_ff[1] <= csr_data;
            default: ;
         endcase
      end
   end

   // setup: dividends for the next-match and prior-match remainders
   always_comb begin
      logic signed [32:0] lim, e;
      prep_in      = '0;
      prep_in.vld  = req_valid;
      prep_in.step = req_step;
      for (int s = 0; s < S; s++) begin
         lim = $signed({2'b0, req_step}) - 33'sd1;
         if (lim > $signed({2'b0, stop_ff[s]})) lim = $signed({2'b0, stop_ff[s]});
         e = lim - $signed({2'b0, start_ff[s]});
         prep_in.lane[s].dge  = req_step >= start_ff[s];
         prep_in.lane[s].eneg = e[32];
         prep_in.lane[s].dq   = {1'b0, req_step - start_ff[s]};
         prep_in.lane[s].eq   = e[32] ? D'(-e) : D'(e);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].vld <= 1'b0;
      end else if (adv) begin
         chain[0].vld <= prep_in.vld;
      end
      if (adv) begin
         chain[0].step <= prep_in.step;
         chain[0].lane <= prep_in.lane;
      end
   end

   for (genvar i = 0; i < D; i++) begin : g_cell
      pisq_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .period (period_ff),
         .item_i (chain[i]),
         .item_o (chain[i+1])
      );
   end

   // remainder lanes carry the magnitude in eq once shifted out; restore it
   pisq_pkg::lane_type [S-1:0] fin_lane;

   for (genvar s = 0; s < S; s++) begin : g_post
      pisq_post u_post (
         .step   (chain[D].step),
         .start  (start_ff[s]),
         .stop   (stop_ff[s]),
         .period (period_ff[s]),
         .lane   (fin_lane[s]),
         .res    (sres[s])
      );
   end

   // the magnitude of e is needed after the cells; carry a copy alongside
   logic [S-1:0][D-1:0] mag_pipe [D+1];
   always_comb begin
      for (int s = 0; s < S; s++) begin
         fin_lane[s]    = chain[D].lane[s];
         fin_lane[s].eq = mag_pipe[D][s];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < S; s++) mag_pipe[0][s] <= prep_in.lane[s].eq;
         for (int i = 0; i < D; i++) mag_pipe[i+1] <= mag_pipe[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= 1'b0;
      end else if (adv) begin
         post_vld_ff <= chain[D].vld;
      end
      if (adv) begin
         sres_ff      <= sres;
         post_step_ff <= chain[D].step;
      end
   end

   always_comb begin
      member_in = sres_ff[0].member || sres_ff[1].member;
      next_in   = (sres_ff[1].nxt < sres_ff[0].nxt) ? sres_ff[1].nxt : sres_ff[0].nxt;
      prior_in  = (sres_ff[1].prv > sres_ff[0].prv) ? sres_ff[1].prv : sres_ff[0].prv;
      if (member_in) prior_in = post_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= post_vld_ff;
      end
      if (adv) begin
         member_ff <= member_in;
         next_ff   <= next_in;
         prior_ff  <= prior_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_member  = member_ff;
   assign rsp_next_step  = next_ff;
   assign rsp_prior_step = prior_ff;
   assign rsp_local_gap  = next_ff - prior_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("response dropped while stalled");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_step >= rsp_prior_step)
      else $error("next below prior");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_step != pisq_pkg::NoneStep |-> rsp_local_gap != '0)
      else $error("zero gap with a real next match");
endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   localparam int StepBits = pisq_pkg::StepBits;
   localparam int CsrBits  = pisq_pkg::CsrBits;
   localparam logic [StepBits-1:0] MaxStep = pisq_pkg::NoneStep;

   typedef struct {
      logic                is_member;
      logic [StepBits-1:0] next_step;
      logic [StepBits-1:0] prior_step;
      logic [StepBits-1:0] local_gap;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [StepBits-1:0] req_step = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_is_member;
   logic [StepBits-1:0] rsp_next_step;
   logic [StepBits-1:0] rsp_prior_step;
   logic [StepBits-1:0] rsp_local_gap;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrBits-1:0]  csr_index = '0;
   logic [StepBits-1:0] csr_data = '0;

   int errors = 0;
   bit stalls_on = 1'b1;

   always #10 clock = ~clock;

   periodic_interval_step_query_unit dut (.*);

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   class slice_scoreboard;
      longint slice_start[2];
      longint slice_stop[2];
      longint slice_period[2];
      answer_type pending[$];

      function new();
         slice_start  = '{0, 0};
         slice_stop   = '{longint'(MaxStep), longint'(MaxStep)};
         slice_period = '{1, 0};
      endfunction

      function void write_reg(logic [CsrBits-1:0] idx, logic [StepBits-1:0] val);
         case (idx)
            pisq_pkg::CsrFirstStart:   slice_start[0] = val;
            pisq_pkg::CsrFirstStop:    slice_stop[0] = val;
            pisq_pkg::CsrFirstPeriod:  slice_period[0] = val;
            pisq_pkg::CsrSecondStart:  slice_start[1] = val;
            pisq_pkg::CsrSecondStop:   slice_stop[1] = val;
            pisq_pkg::CsrSecondPeriod: slice_period[1] = val;
            default: ;
         endcase
      endfunction

      function void note_step(logic [StepBits-1:0] step);
         answer_type a;
         longint n, p, st, nx, pv, lim, cand_n, cand_p;
         bit member;
         n = step;
         member = 0;
         nx = MaxStep;
         pv = 0;
         for (int s = 0; s < 2; s++) begin
            p = slice_period[s];
            st = slice_start[s];
            if (p > 0) begin
               if (n >= st && n <= slice_stop[s] && (n - st) % p == 0)
                  member = 1;
               cand_n = st;
               if (n >= st)
                  cand_n = ((n - st) / p + 1) * p + st;
               if (cand_n > slice_stop[s])
                  cand_n = MaxStep;
               lim = n - 1;
               if (slice_stop[s] < lim)
                  lim = slice_stop[s];
               // SV division truncates toward zero, same as C
               cand_p = ((lim - st) / p) * p + st;
               if (n < st || cand_p < 0)
                  cand_p = 0;
               if (cand_n < nx)
                  nx = cand_n;
               if (cand_p > pv)
                  pv = cand_p;
            end
         end
         if (member)
            pv = n;
         a.is_member  = member;
         a.next_step  = nx[StepBits-1:0];
         a.prior_step = pv[StepBits-1:0];
         a.local_gap  = 31'(nx - pv);
         pending = {pending, a};
      endfunction

      task check_answer(answer_type got);
         answer_type exp;
         if (pending.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         exp = pending.pop_front();
         if (got.is_member !== exp.is_member)
            report($sformatf("is_member %0d exp %0d", got.is_member, exp.is_member));
         if (got.next_step !== exp.next_step)
            report($sformatf("next_step %0d exp %0d", got.next_step, exp.next_step));
         if (got.prior_step !== exp.prior_step)
            report($sformatf("prior_step %0d exp %0d", got.prior_step, exp.prior_step));
         if (got.local_gap !== exp.local_gap)
            report($sformatf("local_gap %0d exp %0d", got.local_gap, exp.local_gap));
      endtask
   endclass

   slice_scoreboard sb = new();

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side: random stall, check on accept
   always @(posedge clock) begin
      answer_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.is_member  = rsp_is_member;
         got.next_step  = rsp_next_step;
         got.prior_step = rsp_prior_step;
         got.local_gap  = rsp_local_gap;
         sb.check_answer(got);
      end
   end

   initial begin
      int g;
      @(negedge clock);
      forever begin
         g = stalls_on ? pick_gap() : 0;
         rsp_ready <= (g == 0);
         if (g != 0) begin
            repeat (g) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   task automatic send_step(input logic [StepBits-1:0] step, input bit pause);
      int g;
      g = pause ? pick_gap() : 0;
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_step  <= step;
      do @(posedge clock); while (!req_ready);
      sb.note_step(step);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrBits-1:0] idx, input logic [StepBits-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic load_slices(input logic [StepBits-1:0] s0, e0, p0, s1, e1, p1);
      write_csr(pisq_pkg::CsrFirstStart, s0);
      write_csr(pisq_pkg::CsrFirstStop, e0);
      write_csr(pisq_pkg::CsrFirstPeriod, p0);
      write_csr(pisq_pkg::CsrSecondStart, s1);
      write_csr(pisq_pkg::CsrSecondStop, e1);
      write_csr(pisq_pkg::CsrSecondPeriod, p1);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [StepBits-1:0] rand_val(input int scale);
      case ($urandom_range(0, 5))
         0: return 31'($urandom_range(0, 3));
         1: return MaxStep - 31'($urandom_range(0, 3));
         2: return 31'($urandom());
         default: return 31'($urandom_range(0, scale));
      endcase
   endfunction

   function automatic logic [StepBits-1:0] rand_period();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 31'($urandom_range(1, 2));
         2: return 31'($urandom());
         3: return MaxStep;
         default: return 31'($urandom_range(1, 60));
      endcase
   endfunction

   initial begin
      logic [StepBits-1:0] base;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: every step matches slice one
      send_step('0, 0);
      send_step(31'd1, 0);
      send_step(MaxStep, 0);
      send_step(MaxStep - 1, 0);
      drain();

      // stop below start, disabled second slice, next runs past stop
      load_slices(31'd100, 31'd50, 31'd7, 31'd10, 31'd200, 31'd0);
      for (int i = 0; i < StepBits; i++) send_step(31'(1) << i, 0);
      send_step(31'd99, 0);
      send_step(31'd100, 0);
      send_step(31'd101, 0);
      drain();
      load_slices(31'd10, 31'd40, 31'd7, 31'd3, 31'd12, 31'd4);
      send_step(31'd0, 0);
      send_step(31'd10, 0);
      send_step(31'd38, 0);
      send_step(31'd39, 0);
      send_step(31'd41, 0);
      send_step(31'd11, 0);
      drain();
      load_slices(MaxStep, MaxStep, MaxStep, '0, MaxStep, MaxStep);
      send_step(MaxStep, 0);
      send_step(MaxStep - 1, 0);
      send_step(31'h2AAAAAAA, 0);
      send_step(31'h55555555, 0);
      drain();

      for (int ph = 0; ph < 30; ph++) begin
         load_slices(rand_val(300), rand_val(600), rand_period(),
                     rand_val(300), rand_val(600), rand_period());
         stalls_on = (ph % 5 != 2);
         base = rand_val(300);
         for (int i = 0; i < 60; i++) begin
            if ($urandom_range(0, 3) == 0)
               send_step(31'($urandom()), stalls_on);
            else if ($urandom_range(0, 9) == 0)
               send_step(MaxStep - 31'($urandom_range(0, 2)), stalls_on);
            else
               send_step(31'(base + $urandom_range(0, 400)), stalls_on);
            if (ph == 7 && i == 30) drain();
         end
         drain();
      end

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
